[src/lr_pkg.sv]
// Shared types, constants and helper functions of the line rasterizer.
`timescale 1ns / 1ps

package lr_pkg;

   // Screen geometry and frame address layout
   localparam int SCREEN_WIDTH  = 640;
   localparam int SCREEN_HEIGHT = 480;
   localparam int ROW_SHIFT     = 10;

   // Field widths
   localparam int IN_W    = 12;
   localparam int COORD_W = 10;
   localparam int ROW_W   = 9;
   localparam int ADDR_W  = 19;
   localparam int COLOUR_W = 8;
   localparam int ERR_W   = COORD_W + 3;

   localparam logic [COORD_W-1:0] COL_MAX = COORD_W'(SCREEN_WIDTH - 1);
   localparam logic [COORD_W-1:0] ROW_MAX = COORD_W'(SCREEN_HEIGHT - 1);

   // Request kinds
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_NEXT  = 1'b1;

   // Step codes
   localparam logic signed [1:0] STEP_NEG  = 2'sb11;
   localparam logic signed [1:0] STEP_NONE = 2'sb00;
   localparam logic signed [1:0] STEP_POS  = 2'sb01;

   typedef struct packed {
      logic                       req_type;
      logic signed [IN_W-1:0]     x_start;
      logic signed [IN_W-1:0]     y_start;
      logic signed [IN_W-1:0]     x_end;
      logic signed [IN_W-1:0]     y_end;
      logic [COLOUR_W-1:0]        colour;
   } req_item_type;

   typedef struct packed {
      logic                       pixel_valid;
      logic [COORD_W-1:0]         pixel_col;
      logic [ROW_W-1:0]           pixel_row;
      logic [ADDR_W-1:0]          pixel_addr;
      logic [COLOUR_W-1:0]        pixel_colour;
      logic                       is_last;
   } rsp_item_type;

   // Line set-up worked out from a start request
   typedef struct packed {
      logic [COORD_W-1:0]         col;
      logic [COORD_W-1:0]         row;
      logic signed [ERR_W-1:0]    err;
      logic [COORD_W-1:0]         major;
      logic [COORD_W-1:0]         minor;
      logic signed [1:0]          col_step;
      logic signed [1:0]          row_step;
      logic                       swapped;
   } setup_type;

   // Saturate a signed coordinate to 0..hi
   function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [IN_W-1:0] v,
                                                     input logic [COORD_W-1:0] hi);
      logic signed [IN_W-1:0] hi_s;
      hi_s = IN_W'(hi);
      if (v < 0)
         return '0;
      else if (v > hi_s)
         return hi;
      else
         return v[COORD_W-1:0];
   endfunction

   // Move a coordinate one step, wrapping at its width
   function automatic logic [COORD_W-1:0] add_step(input logic [COORD_W-1:0] v,
                                                  input logic signed [1:0] s);
      return v + {{(COORD_W-2){s[1]}}, s};
   endfunction

endpackage

[src/lr_in_stage.sv]
// Input register of the line rasterizer.
`timescale 1ns / 1ps

module lr_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lr_pkg::req_item_type  req_data,
   output logic                  item_valid,
   output lr_pkg::req_item_type  item_data,
   input  logic                  item_take
);

   logic                 valid_ff;
   lr_pkg::req_item_type data_ff;

   // Take a new item when empty or when the held one moves on
   assign req_ready  = !valid_ff || item_take;
   assign item_valid = valid_ff;
   assign item_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   // Hold the payload until the next item arrives
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         data_ff <= req_data;
      end
   end

endmodule

[src/lr_setup.sv]
// Line set-up: endpoint clamping, deltas, step signs, axis swap and error seed.
`timescale 1ns / 1ps

module lr_setup (
   input  lr_pkg::req_item_type item,
   output lr_pkg::setup_type    setup
);

   logic [lr_pkg::COORD_W-1:0] x1, y1, x2, y2;
   logic [lr_pkg::COORD_W-1:0] dx, dy;
   logic signed [1:0]          cs, rs;
   logic                       swap;
   logic [lr_pkg::COORD_W-1:0] major, minor;

   always_comb begin
      // Saturate endpoints to the screen
      x1 = lr_pkg::clamp_coord(item.x_start, lr_pkg::COL_MAX);
      y1 = lr_pkg::clamp_coord(item.y_start, lr_pkg::ROW_MAX);
      x2 = lr_pkg::clamp_coord(item.x_end,   lr_pkg::COL_MAX);
      y2 = lr_pkg::clamp_coord(item.y_end,   lr_pkg::ROW_MAX);

      // Absolute deltas and step directions
      if (x2 < x1) begin
         dx = x1 - x2;
         cs = lr_pkg::STEP_NEG;
      end else if (x2 == x1) begin
         dx = '0;
         cs = lr_pkg::STEP_NONE;
      end else begin
         dx = x2 - x1;
         cs = lr_pkg::STEP_POS;
      end
      if (y2 < y1) begin
         dy = y1 - y2;
         rs = lr_pkg::STEP_NEG;
      end else if (y2 == y1) begin
         dy = '0;
         rs = lr_pkg::STEP_NONE;
      end else begin
         dy = y2 - y1;
         rs = lr_pkg::STEP_POS;
      end

      // Steep lines walk along the rows
      swap  = dy > dx;
      major = swap ? dy : dx;
      minor = swap ? dx : dy;

      setup.col      = x1;
      setup.row      = y1;
      setup.err      = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
      setup.major    = major;
      setup.minor    = minor;
      setup.col_step = cs;
      setup.row_step = rs;
      setup.swapped  = swap;
   end

endmodule

[src/lr_engine.sv]
// Bresenham stepping engine: line state, pixel formation and result register.
`timescale 1ns / 1ps

module lr_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  lr_pkg::req_item_type  item_data,
   input  lr_pkg::setup_type     setup,
   output logic                  item_take,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lr_pkg::rsp_item_type  rsp_data
);

   // Line state
   logic [lr_pkg::COORD_W-1:0]       col_ff, row_ff;
   logic signed [lr_pkg::ERR_W-1:0]  err_ff;
   logic [lr_pkg::COORD_W-1:0]       major_ff, minor_ff, left_ff;
   logic signed [1:0]                cstep_ff, rstep_ff;
   logic                             swapped_ff, active_ff;
   logic [lr_pkg::COLOUR_W-1:0]      colour_ff;

   logic [lr_pkg::COORD_W-1:0]       col_in, row_in;
   logic signed [lr_pkg::ERR_W-1:0]  err_in;
   logic [lr_pkg::COORD_W-1:0]       major_in, minor_in, left_in;
   logic signed [1:0]                cstep_in, rstep_in;
   logic                             swapped_in, active_in;
   logic [lr_pkg::COLOUR_W-1:0]      colour_in;

   // Result register
   logic                  out_valid_ff;
   lr_pkg::rsp_item_type  out_ff, out_in;

   // Working values for this item
   logic                             start, active, last, bump;
   logic [lr_pkg::COORD_W-1:0]       cur_col, cur_row;
   logic signed [lr_pkg::ERR_W-1:0]  cur_err;
   logic [lr_pkg::COORD_W-1:0]       cur_major, cur_minor, cur_left;
   logic signed [1:0]                cur_cs, cur_rs;
   logic                             cur_swap;
   logic [lr_pkg::COLOUR_W-1:0]      cur_colour;
   logic [lr_pkg::ADDR_W-1:0]        row_ext;

   assign item_take = item_valid && (!out_valid_ff || rsp_ready);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      start = item_data.req_type == lr_pkg::REQ_START;

      // Pick set-up values on a start, held state otherwise
      if (start) begin
         cur_col    = setup.col;
         cur_row    = setup.row;
         cur_err    = setup.err;
         cur_major  = setup.major;
         cur_minor  = setup.minor;
         cur_left   = setup.major;
         cur_cs     = setup.col_step;
         cur_rs     = setup.row_step;
         cur_swap   = setup.swapped;
         cur_colour = item_data.colour;
         active     = 1'b1;
      end else begin
         cur_col    = col_ff;
         cur_row    = row_ff;
         cur_err    = err_ff;
         cur_major  = major_ff;
         cur_minor  = minor_ff;
         cur_left   = left_ff;
         cur_cs     = cstep_ff;
         cur_rs     = rstep_ff;
         cur_swap   = swapped_ff;
         cur_colour = colour_ff;
         active     = active_ff;
      end
      last = cur_left == '0;
      bump = !cur_err[lr_pkg::ERR_W-1];

      // Form the pixel
      row_ext = lr_pkg::ADDR_W'(cur_row[lr_pkg::ROW_W-1:0]);
      out_in  = '0;
      if (active) begin
         out_in.pixel_valid  = 1'b1;
         out_in.pixel_col    = cur_col;
         out_in.pixel_row    = cur_row[lr_pkg::ROW_W-1:0];
         out_in.pixel_addr   = (row_ext << lr_pkg::ROW_SHIFT)
                               + lr_pkg::ADDR_W'(cur_col);
         out_in.pixel_colour = cur_colour;
         out_in.is_last      = last;
      end

      // Advance an active line short of its last pixel: minor axis on a non-negative error, major axis always
      major_in   = cur_major;
      minor_in   = cur_minor;
      cstep_in   = cur_cs;
      rstep_in   = cur_rs;
      swapped_in = cur_swap;
      colour_in  = cur_colour;
      col_in     = cur_col;
      row_in     = cur_row;
      err_in     = cur_err;
      left_in    = cur_left;
      active_in  = active;
      if (active) begin
         if (last) begin
            active_in = 1'b0;
         end else begin
            if (cur_swap) begin
               row_in = lr_pkg::add_step(cur_row, cur_rs);
               if (bump)
                  col_in = lr_pkg::add_step(cur_col, cur_cs);
            end else begin
               col_in = lr_pkg::add_step(cur_col, cur_cs);
               if (bump)
                  row_in = lr_pkg::add_step(cur_row, cur_rs);
            end
            err_in = cur_err
                     - (bump ? $signed({2'b00, cur_major, 1'b0}) : '0)
                     + $signed({2'b00, cur_minor, 1'b0});
            left_in = cur_left - 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (item_take)
            active_ff <= active_in;
         if (item_take)
            out_valid_ff <= 1'b1;
         else if (rsp_ready)
            out_valid_ff <= 1'b0;
      end
   end

   // Line state and result payload
   always_ff @(posedge clock) begin
      if (item_take) begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         err_ff     <= err_in;
         major_ff   <= major_in;
         minor_ff   <= minor_in;
         left_ff    <= left_in;
         cstep_ff   <= cstep_in;
         rstep_ff   <= rstep_in;
         swapped_ff <= swapped_in;
         colour_ff  <= colour_in;
         out_ff     <= out_in;
      end
   end

endmodule

[src/line_rasterizer.sv]
// Top level of the Bresenham line rasterizer.
`timescale 1ns / 1ps

// Every request gives exactly one result: a start request (req_type 0) clamps
// both endpoints to the 640x480 screen, sets up the line and returns its first
// pixel; each next request (req_type 1) returns the following pixel, with
// pixel_addr = (row << 10) + column, and is_last marks the final one. A next
// request with no line in progress returns an all-zero result with
// pixel_valid low. A request passes an input register and then the stepping
// engine, whose result register is loaded when the engine takes the request.
// One request is taken every cycle while results are drained; the line state
// in the engine is updated as each request is taken, which sets this rate.
module line_rasterizer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lr_pkg::req_item_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lr_pkg::rsp_item_type  rsp_data
);

   logic                 item_valid, item_take;
   lr_pkg::req_item_type item_data;
   lr_pkg::setup_type    setup;

   lr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_take  (item_take)
   );

   lr_setup u_setup (
      .item  (item_data),
      .setup (setup)
   );

   lr_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_data  (item_data),
      .setup      (setup),
      .item_take  (item_take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
